>>> rtl/box_filter_downsampler_unit_defines.svh
// assertion macros for the box filter downsampler checker
// depends on clk_i and rst_ni in the scope where a macro is used
`ifndef BOX_FILTER_DOWNSAMPLER_UNIT_DEFINES_SVH
`define BOX_FILTER_DOWNSAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define BFD_ASSERT_IMPL(name, ant, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("bfd: same-cycle check failed");

// next-cycle implication
`define BFD_ASSERT_NEXT(name, ant, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("bfd: next-cycle check failed");

`endif

>>> rtl/bfd_pkg.sv
// shared types and constants of the box filter downsampler
// no dependencies
`default_nettype none

package bfd_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned SumW       = 16;
  localparam int unsigned OutWidthW  = 7;
  localparam int unsigned ChanMax    = 255;
  localparam int unsigned MidDepth   = 4;
  localparam int unsigned OutDepth   = 8;
  localparam int unsigned OutCntW    = $clog2(OutDepth + 1);

  localparam logic [OutWidthW-1:0] OutWidthDefault = 7'd16;
  localparam logic [ChanW-1:0]     TranspLimit     = 8'd32;

  typedef struct packed {
    logic [SumW-1:0] alpha;
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sums_t;

  typedef struct packed {
    sums_t sums;
    logic  row_end;
    logic  frame_end;
  } mid_item_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             transparent;
    logic             row_end;
    logic             frame_end;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/bfd_fifo.sv
// small register queue used between front and back and at the output
// no dependencies
`default_nettype none

module bfd_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [W-1:0]                   data_i,
  output logic                                full_o,
  input  wire logic                           pop_i,
  output logic [W-1:0]                        data_o,
  output logic                                empty_o,
  output logic [$clog2(DEPTH+1)-1:0]          count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bfd_front.sv
// front part: raster position counters, width register and per-column line sums
// depends on bfd_pkg; pushes finished block sums into the middle queue
`default_nettype none

module bfd_front
  import bfd_pkg::*;
#(
  parameter int unsigned FACTOR        = 16,
  parameter int unsigned MAX_OUT_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  out_width_we_i,
  input  wire logic [OutWidthW-1:0]  out_width_i,
  input  wire logic                  push_i,
  input  wire logic [ChanW-1:0]      in_alpha_i,
  input  wire logic [ChanW-1:0]      in_red_i,
  input  wire logic [ChanW-1:0]      in_green_i,
  input  wire logic [ChanW-1:0]      in_blue_i,
  input  wire logic                  mid_full_i,
  output logic                       mid_push_o,
  output mid_item_t                  mid_data_o
);

  localparam int unsigned SubW = $clog2(FACTOR);
  localparam int unsigned ColW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int unsigned EffW = $clog2(MAX_OUT_WIDTH + 1);
  localparam int unsigned CmpW = (EffW > OutWidthW) ? EffW : OutWidthW;

  logic [OutWidthW-1:0] out_width_q;
  logic [SubW-1:0]      sub_col_q, sub_col_d;
  logic [SubW-1:0]      sub_row_q, sub_row_d;
  logic [ColW-1:0]      blk_col_q, blk_col_d;
  logic [ColW-1:0]      blk_row_q, blk_row_d;
  logic [CmpW-1:0]      width_wide;
  logic [EffW-1:0]      eff_w;
  logic                 acc, first_seg, last_seg, first_row, last_row;
  logic                 last_col, last_blk_row;
  sums_t                pix, base, total, seg_d, seg_q, rd_q;
  sums_t                line_mem [MAX_OUT_WIDTH];

  assign acc = push_i && !mid_full_i;

  always_comb begin
    width_wide = CmpW'(out_width_q);
    if (width_wide == '0) begin
      width_wide = CmpW'(OutWidthDefault);
    end
    if (width_wide > CmpW'(MAX_OUT_WIDTH)) begin
      width_wide = CmpW'(MAX_OUT_WIDTH);
    end
    eff_w = EffW'(width_wide);
  end

  assign first_seg    = (sub_col_q == '0);
  assign last_seg     = (sub_col_q == SubW'(FACTOR - 1));
  assign first_row    = (sub_row_q == '0);
  assign last_row     = (sub_row_q == SubW'(FACTOR - 1));
  assign last_col     = (EffW'(blk_col_q) == eff_w - EffW'(1));
  assign last_blk_row = (EffW'(blk_row_q) == eff_w - EffW'(1));

  // colour counts only where alpha is nonzero
  always_comb begin
    pix.alpha = SumW'(in_alpha_i);
    pix.red   = (in_alpha_i == '0) ? '0 : SumW'(in_red_i);
    pix.green = (in_alpha_i == '0) ? '0 : SumW'(in_green_i);
    pix.blue  = (in_alpha_i == '0) ? '0 : SumW'(in_blue_i);
  end

  always_comb begin
    base        = first_row ? '0 : rd_q;
    total.alpha = base.alpha + seg_q.alpha + pix.alpha;
    total.red   = base.red + seg_q.red + pix.red;
    total.green = base.green + seg_q.green + pix.green;
    total.blue  = base.blue + seg_q.blue + pix.blue;
    if (first_seg) begin
      seg_d = pix;
    end else begin
      seg_d.alpha = seg_q.alpha + pix.alpha;
      seg_d.red   = seg_q.red + pix.red;
      seg_d.green = seg_q.green + pix.green;
      seg_d.blue  = seg_q.blue + pix.blue;
    end
  end

  assign mid_push_o           = acc && last_seg && last_row;
  assign mid_data_o.sums      = total;
  assign mid_data_o.row_end   = last_col;
  assign mid_data_o.frame_end = last_col && last_blk_row;

  always_comb begin
    sub_col_d = sub_col_q;
    blk_col_d = blk_col_q;
    sub_row_d = sub_row_q;
    blk_row_d = blk_row_q;
    if (acc) begin
      sub_col_d = sub_col_q + SubW'(1);
      if (last_seg) begin
        sub_col_d = '0;
        blk_col_d = blk_col_q + ColW'(1);
        if (last_col) begin
          blk_col_d = '0;
          sub_row_d = sub_row_q + SubW'(1);
          if (last_row) begin
            sub_row_d = '0;
            blk_row_d = last_blk_row ? '0 : blk_row_q + ColW'(1);
          end
        end
      end
    end
    if (out_width_we_i) begin
      sub_col_d = '0;
      blk_col_d = '0;
      sub_row_d = '0;
      blk_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q <= OutWidthDefault;
      sub_col_q   <= '0;
      blk_col_q   <= '0;
      sub_row_q   <= '0;
      blk_row_q   <= '0;
    end else begin
      if (out_width_we_i) begin
        out_width_q <= out_width_i;
      end
      sub_col_q <= sub_col_d;
      blk_col_q <= blk_col_d;
      sub_row_q <= sub_row_d;
      blk_row_q <= blk_row_d;
    end
  end

  // line sums: read on the first pixel of a column segment, written on its last
  always_ff @(posedge clk_i) begin
    if (acc) begin
      seg_q <= seg_d;
    end
    if (acc && first_seg) begin
      rd_q <= line_mem[blk_col_q];
    end
    if (acc && last_seg) begin
      line_mem[blk_col_q] <= total;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bfd_back.sv
// back part: four-stage averaging pipeline from block sums to output pixels
// depends on bfd_pkg; pulls from the middle queue only when the output queue has room
`default_nettype none

module bfd_back
  import bfd_pkg::*;
#(
  parameter int unsigned FACTOR = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                mid_valid_i,
  input  wire mid_item_t           mid_data_i,
  output logic                     mid_pop_o,
  input  wire logic [OutCntW-1:0]  out_count_i,
  output logic                     out_push_o,
  output result_t                  out_data_o
);

  localparam int unsigned Samples  = FACTOR * FACTOR;
  localparam logic [31:0] SampD    = 32'(Samples);
  localparam logic [31:0] SampRcp  = 32'(65536 / Samples);
  localparam logic [31:0] ChanD    = 32'(ChanMax);
  localparam logic [31:0] ChanRcp  = 32'(65536 / ChanMax);
  localparam int unsigned CredW    = OutCntW + 1;

  // quotient estimate by reciprocal, low by at most one
  function automatic logic [SumW-1:0] rcp_est(input logic [SumW-1:0] s,
                                              input logic [31:0] m);
    logic [31:0] p;
    p = {16'b0, s} * m;
    return p[31:16];
  endfunction

  function automatic logic [SumW-1:0] rcp_fix(input logic [SumW-1:0] s,
                                              input logic [SumW-1:0] q0,
                                              input logic [31:0] d);
    logic [31:0] rem;
    rem = {16'b0, s} - ({16'b0, q0} * d);
    return (rem >= d) ? q0 + SumW'(1) : q0;
  endfunction

  logic [3:0]             v_q;
  logic [2:0]             inflight;
  logic                   pull;

  sums_t                  s1_sum_q, s1_est_q;
  logic                   s1_re_q, s1_fe_q;
  logic [ChanW-1:0]       s2_a_q, s2_r_q, s2_g_q, s2_b_q;
  logic                   s2_re_q, s2_fe_q;
  logic [SumW-1:0]        s3_pr_q, s3_pg_q, s3_pb_q;
  logic [ChanW-1:0]       s3_a_q;
  logic                   s3_re_q, s3_fe_q;
  logic [SumW-1:0]        s4_pr_q, s4_pg_q, s4_pb_q;
  logic [SumW-1:0]        s4_er_q, s4_eg_q, s4_eb_q;
  logic [ChanW-1:0]       s4_a_q;
  logic                   s4_re_q, s4_fe_q;
  logic [SumW-1:0]        fix_r, fix_g, fix_b;

  assign inflight  = 3'($countones(v_q));
  assign pull      = mid_valid_i
                     && ((CredW'(out_count_i) + CredW'(inflight)) < CredW'(OutDepth));
  assign mid_pop_o = pull;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], pull};
    end
  end

  always_ff @(posedge clk_i) begin
    // block sum over samples
    s1_sum_q       <= mid_data_i.sums;
    s1_est_q.alpha <= rcp_est(mid_data_i.sums.alpha, SampRcp);
    s1_est_q.red   <= rcp_est(mid_data_i.sums.red, SampRcp);
    s1_est_q.green <= rcp_est(mid_data_i.sums.green, SampRcp);
    s1_est_q.blue  <= rcp_est(mid_data_i.sums.blue, SampRcp);
    s1_re_q        <= mid_data_i.row_end;
    s1_fe_q        <= mid_data_i.frame_end;

    s2_a_q  <= ChanW'(rcp_fix(s1_sum_q.alpha, s1_est_q.alpha, SampD));
    s2_r_q  <= ChanW'(rcp_fix(s1_sum_q.red, s1_est_q.red, SampD));
    s2_g_q  <= ChanW'(rcp_fix(s1_sum_q.green, s1_est_q.green, SampD));
    s2_b_q  <= ChanW'(rcp_fix(s1_sum_q.blue, s1_est_q.blue, SampD));
    s2_re_q <= s1_re_q;
    s2_fe_q <= s1_fe_q;

    // premultiply
    s3_pr_q <= {8'b0, s2_r_q} * {8'b0, s2_a_q};
    s3_pg_q <= {8'b0, s2_g_q} * {8'b0, s2_a_q};
    s3_pb_q <= {8'b0, s2_b_q} * {8'b0, s2_a_q};
    s3_a_q  <= s2_a_q;
    s3_re_q <= s2_re_q;
    s3_fe_q <= s2_fe_q;

    s4_pr_q <= s3_pr_q;
    s4_pg_q <= s3_pg_q;
    s4_pb_q <= s3_pb_q;
    s4_er_q <= rcp_est(s3_pr_q, ChanRcp);
    s4_eg_q <= rcp_est(s3_pg_q, ChanRcp);
    s4_eb_q <= rcp_est(s3_pb_q, ChanRcp);
    s4_a_q  <= s3_a_q;
    s4_re_q <= s3_re_q;
    s4_fe_q <= s3_fe_q;
  end

  assign fix_r = rcp_fix(s4_pr_q, s4_er_q, ChanD);
  assign fix_g = rcp_fix(s4_pg_q, s4_eg_q, ChanD);
  assign fix_b = rcp_fix(s4_pb_q, s4_eb_q, ChanD);

  assign out_push_o             = v_q[3];
  assign out_data_o.alpha       = s4_a_q;
  assign out_data_o.red         = fix_r[ChanW-1:0];
  assign out_data_o.green       = fix_g[ChanW-1:0];
  assign out_data_o.blue        = fix_b[ChanW-1:0];
  assign out_data_o.transparent = (s4_a_q < TranspLimit);
  assign out_data_o.row_end     = s4_re_q;
  assign out_data_o.frame_end   = s4_fe_q;

endmodule

`default_nettype wire

>>> rtl/box_filter_downsampler_unit.sv
// box filter downsampler top level: one pixel transfer per cycle while full is low
// a result reaches the output ports after the transfer of a block's last pixel by way of
// the middle queue, the four-stage averaging pipeline and the output queue
// the line-sum memory takes at most one read or one write per pixel
// reset clears position counters and queues and sets out_width to 16; line sums need no clear
`default_nettype none

module box_filter_downsampler_unit
  import bfd_pkg::*;
#(
  parameter int unsigned FACTOR        = 16,
  parameter int unsigned MAX_OUT_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  out_width_we_i,
  input  wire logic [OutWidthW-1:0]  out_width_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [ChanW-1:0]      in_alpha_i,
  input  wire logic [ChanW-1:0]      in_red_i,
  input  wire logic [ChanW-1:0]      in_green_i,
  input  wire logic [ChanW-1:0]      in_blue_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [ChanW-1:0]           out_alpha_o,
  output logic [ChanW-1:0]           out_red_o,
  output logic [ChanW-1:0]           out_green_o,
  output logic [ChanW-1:0]           out_blue_o,
  output logic                       transparent_bit_o,
  output logic                       row_end_o,
  output logic                       frame_end_o
);

  localparam int unsigned MidW  = $bits(mid_item_t);
  localparam int unsigned ResW  = $bits(result_t);
  localparam int unsigned MidCW = $clog2(MidDepth + 1);

  logic                mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t           mid_wdata, mid_rdata;
  logic [MidW-1:0]     mid_rvec;
  logic [MidCW-1:0]    mid_count;
  logic                out_push;
  result_t             out_wdata, out_rdata;
  logic [ResW-1:0]     out_rvec;
  logic [OutCntW-1:0]  out_count;
  logic                out_full;

  assign full = mid_full;

  bfd_front #(
    .FACTOR       (FACTOR),
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .out_width_we_i(out_width_we_i),
    .out_width_i   (out_width_i),
    .push_i        (push),
    .in_alpha_i    (in_alpha_i),
    .in_red_i      (in_red_i),
    .in_green_i    (in_green_i),
    .in_blue_i     (in_blue_i),
    .mid_full_i    (mid_full),
    .mid_push_o    (mid_push),
    .mid_data_o    (mid_wdata)
  );

  bfd_fifo #(
    .W    (MidW),
    .DEPTH(MidDepth)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_wdata),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .data_o (mid_rvec),
    .empty_o(mid_empty),
    .count_o(mid_count)
  );

  assign mid_rdata = mid_item_t'(mid_rvec);

  bfd_back #(
    .FACTOR(FACTOR)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_valid_i(!mid_empty && (mid_count != '0)),
    .mid_data_i (mid_rdata),
    .mid_pop_o  (mid_pop),
    .out_count_i(out_count),
    .out_push_o (out_push),
    .out_data_o (out_wdata)
  );

  bfd_fifo #(
    .W    (ResW),
    .DEPTH(OutDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_wdata),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_rvec),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign out_rdata         = result_t'(out_rvec);
  assign out_alpha_o       = out_rdata.alpha;
  assign out_red_o         = out_rdata.red;
  assign out_green_o       = out_rdata.green;
  assign out_blue_o        = out_rdata.blue;
  assign transparent_bit_o = out_rdata.transparent && !out_full | out_rdata.transparent;
  assign row_end_o         = out_rdata.row_end;
  assign frame_end_o       = out_rdata.frame_end;

endmodule

`default_nettype wire

>>> rtl/bfd_checker.sv
// port-level checks for the box filter downsampler, bound to the top level
// depends on bfd_pkg and box_filter_downsampler_unit_defines.svh
`default_nettype none

`include "box_filter_downsampler_unit_defines.svh"

module bfd_checker
  import bfd_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [ChanW-1:0]      out_alpha_o,
  input wire logic [ChanW-1:0]      out_red_o,
  input wire logic [ChanW-1:0]      out_green_o,
  input wire logic [ChanW-1:0]      out_blue_o,
  input wire logic                  transparent_bit_o,
  input wire logic                  row_end_o,
  input wire logic                  frame_end_o
);

  logic premul_ok;

  assign premul_ok = (out_red_o <= out_alpha_o) && (out_green_o <= out_alpha_o)
                     && (out_blue_o <= out_alpha_o);

  // frame end only on the last pixel of a row
  `BFD_ASSERT_IMPL(a_frame_end_row_end, !empty && frame_end_o, row_end_o)

  `BFD_ASSERT_IMPL(a_mask_bit, !empty, transparent_bit_o == (out_alpha_o < TranspLimit))

  // premultiplied colour never exceeds alpha
  `BFD_ASSERT_IMPL(a_premul_bound, !empty, premul_ok)

  `BFD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_alpha_o) && $stable(frame_end_o))

endmodule

bind box_filter_downsampler_unit bfd_checker u_bfd_checker (.*);

`default_nettype wire
